>>> rtl/dmc_pkg.sv
// Shared types and codes for the direct-mapped write-back data cache.
package dmc_pkg;

  // Request operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Word address is split into this many 8-bit chunks for the line index remainder
  localparam int unsigned DIV_STEPS = 4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        cacheable;
    logic [31:0] mem_read_data;
  } dmc_req_t;

  localparam int unsigned REQ_W = $bits(dmc_req_t);

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOOK,
    BK_EMIT,
    BK_FLUSH_RD,
    BK_FLUSH_CHK
  } bk_state_t;

endpackage

>>> rtl/dmc_fifo.sv
// Two-entry request queue between the front and back ends.
module dmc_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/dmc_front.sv
// Front end: takes requests, works out the line index and queues them.
module dmc_front #(
  parameter int unsigned NUM_LINES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic        cacheable,
  input  logic [31:0] mem_read_data,
  output logic        push,
  output logic [dmc_pkg::REQ_W+$clog2(NUM_LINES)-1:0] push_data,
  input  logic        q_full
);
  import dmc_pkg::*;

  localparam int unsigned IDX_W   = $clog2(NUM_LINES);
  localparam bit          IS_POW2 = ((NUM_LINES & (NUM_LINES - 1)) == 0);
  localparam logic [IDX_W:0] LINES_C = (IDX_W + 1)'(NUM_LINES);

  fe_state_t   state;
  fe_state_t   state_next;
  dmc_req_t    hold;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rem_next;
  logic [31:0] div_word;
  logic [1:0]  div_cnt;
  logic        accept;

  assign accept = req_valid && (state == FE_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      FE_IDLE: if (req_valid) state_next = IS_POW2 ? FE_PUSH : FE_DIV;
      FE_DIV:  if (div_cnt == 2'(DIV_STEPS - 1)) state_next = FE_PUSH;
      FE_PUSH: if (!q_full) state_next = FE_IDLE;
      default: state_next = FE_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != FE_IDLE);
    push      = (state == FE_PUSH) && !q_full;
    push_data = {hold, idx};
  end

  // Restoring remainder, eight address bits a cycle
  always_comb begin
    logic [IDX_W-1:0] r;
    logic [IDX_W:0]   t;
    r = idx;
    for (int i = 0; i < 8; i++) begin
      t = {r, div_word[31-i]};
      if (t >= LINES_C) t = t - LINES_C;
      r = t[IDX_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.operation     <= operation;
      hold.address       <= address;
      hold.write_data    <= write_data;
      hold.cacheable     <= cacheable;
      hold.mem_read_data <= mem_read_data;
      idx                <= IS_POW2 ? address[IDX_W+1:2] : '0;
      div_word           <= {2'b00, address[31:2]};
      div_cnt            <= 2'd0;
    end else if (state == FE_DIV) begin
      idx      <= rem_next;
      div_word <= div_word << 8;
      div_cnt  <= div_cnt + 2'd1;
    end
  end

endmodule

>>> rtl/dmc_back.sv
// Back end: line store, hit/miss handling, flush sweep and result register.
module dmc_back #(
  parameter int unsigned NUM_LINES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [dmc_pkg::REQ_W+$clog2(NUM_LINES)-1:0] head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  kind,
  output logic [31:0] mem_address,
  output logic [31:0] data,
  output logic        hit,
  output logic        last
);
  import dmc_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_LINES);

  bk_state_t state;
  bk_state_t state_next;

  // Line store
  logic [31:0] line_address [NUM_LINES];
  logic [31:0] line_word    [NUM_LINES];
  logic [NUM_LINES-1:0] line_valid;
  logic [NUM_LINES-1:0] line_dirty;
  logic [31:0] rd_tag;
  logic [31:0] rd_word;
  logic [IDX_W-1:0] ram_raddr;

  dmc_req_t         head_req;
  logic [IDX_W-1:0] head_idx;
  dmc_req_t         cur;
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] flush_idx;

  // Pending results of the current request
  logic        pend_wb;
  logic        pend_rd;
  logic [31:0] wb_addr;
  logic [31:0] wb_data;
  logic [31:0] rd_addr;
  logic [31:0] done_data;
  logic        done_hit;

  // Lookup decisions
  logic        cur_v;
  logic        cur_d;
  logic        line_hit;
  logic        look_wb;
  logic        look_rd;
  logic        look_we;
  logic        look_dirty;
  logic [31:0] look_wb_addr;
  logic [31:0] look_wb_data;
  logic [31:0] look_wword;
  logic [31:0] look_done_data;
  logic        look_done_hit;

  logic slot_free;
  logic flush_dirty;
  logic flush_step;
  logic flush_last;
  logic emit_load;
  logic flush_load;

  assign head_req = head[REQ_W+IDX_W-1:IDX_W];
  assign head_idx = head[IDX_W-1:0];

  assign slot_free   = !rsp_valid || !rsp_stall;
  assign flush_dirty = line_valid[flush_idx] && line_dirty[flush_idx];
  assign flush_step  = !flush_dirty || slot_free;
  assign flush_last  = (flush_idx == IDX_W'(NUM_LINES - 1));
  assign cur_v       = line_valid[cur_idx];
  assign cur_d       = line_dirty[cur_idx];
  assign line_hit    = cur_v && (rd_tag == cur.address);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = (head_req.operation == OP_FLUSH) ? BK_FLUSH_RD : BK_LOOK;
        end
      end
      BK_LOOK:     state_next = BK_EMIT;
      BK_EMIT:     if (slot_free && !pend_wb && !pend_rd) state_next = BK_IDLE;
      BK_FLUSH_RD: state_next = BK_FLUSH_CHK;
      BK_FLUSH_CHK: begin
        if (flush_step) state_next = flush_last ? BK_EMIT : BK_FLUSH_RD;
      end
      default:     state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = (state == BK_IDLE) && !q_empty;
    emit_load  = (state == BK_EMIT) && slot_free;
    flush_load = (state == BK_FLUSH_CHK) && flush_dirty && slot_free;
    unique case (state)
      BK_IDLE:                   ram_raddr = head_idx;
      // keep the swept line on the read port while a write-back waits
      BK_FLUSH_RD, BK_FLUSH_CHK: ram_raddr = flush_idx;
      default:                   ram_raddr = cur_idx;
    endcase
  end

  always_comb begin
    look_wb        = 1'b0;
    look_rd        = 1'b0;
    look_we        = 1'b0;
    look_dirty     = 1'b0;
    look_wb_addr   = rd_tag;
    look_wb_data   = rd_word;
    look_wword     = cur.mem_read_data;
    look_done_data = 32'd0;
    look_done_hit  = 1'b0;
    unique case (cur.operation)
      OP_READ: begin
        if (!cur.cacheable) begin
          look_rd        = 1'b1;
          look_done_data = cur.mem_read_data;
        end else if (line_hit) begin
          look_done_data = rd_word;
          look_done_hit  = 1'b1;
        end else begin
          look_wb        = cur_v && cur_d;
          look_rd        = 1'b1;
          look_we        = 1'b1;
          look_done_data = cur.mem_read_data;
        end
      end
      OP_WRITE: begin
        look_wword = cur.write_data;
        if (!cur.cacheable) begin
          look_wb      = 1'b1;
          look_wb_addr = cur.address;
          look_wb_data = cur.write_data;
        end else begin
          look_wb    = cur_v && cur_d && (rd_tag != cur.address);
          look_we    = 1'b1;
          look_dirty = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if ((state == BK_LOOK) && look_we) begin
      line_address[cur_idx] <= cur.address;
      line_word[cur_idx]    <= look_wword;
    end
    rd_tag  <= line_address[ram_raddr];
    rd_word <= line_word[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      line_valid <= '0;
      line_dirty <= '0;
      pend_wb    <= 1'b0;
      pend_rd    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == BK_LOOK) && look_we) begin
        line_valid[cur_idx] <= 1'b1;
        line_dirty[cur_idx] <= look_dirty;
      end
      if (flush_load) begin
        line_dirty[flush_idx] <= 1'b0;
      end
      if (state == BK_LOOK) begin
        pend_wb <= look_wb;
        pend_rd <= look_rd;
      end else if (emit_load) begin
        if (pend_wb) begin
          pend_wb <= 1'b0;
        end else begin
          pend_rd <= 1'b0;
        end
      end
      if (emit_load || flush_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur       <= head_req;
      cur_idx   <= head_idx;
      flush_idx <= '0;
    end
    if ((state == BK_FLUSH_CHK) && flush_step && !flush_last) begin
      flush_idx <= flush_idx + IDX_W'(1);
    end
    if (state == BK_LOOK) begin
      wb_addr   <= look_wb_addr;
      wb_data   <= look_wb_data;
      rd_addr   <= cur.address;
      done_data <= look_done_data;
      done_hit  <= look_done_hit;
    end else if ((state == BK_FLUSH_CHK) && flush_step && flush_last) begin
      done_data <= 32'd0;
      done_hit  <= 1'b0;
    end
    if (flush_load) begin
      kind        <= KIND_WRITE;
      mem_address <= rd_tag;
      data        <= rd_word;
      hit         <= 1'b0;
      last        <= 1'b0;
    end else if (emit_load) begin
      priority if (pend_wb) begin
        kind        <= KIND_WRITE;
        mem_address <= wb_addr;
        data        <= wb_data;
        hit         <= 1'b0;
        last        <= 1'b0;
      end else if (pend_rd) begin
        kind        <= KIND_READ;
        mem_address <= rd_addr;
        data        <= 32'd0;
        hit         <= 1'b0;
        last        <= 1'b0;
      end else begin
        kind        <= KIND_DONE;
        mem_address <= 32'd0;
        data        <= done_data;
        hit         <= done_hit;
        last        <= 1'b1;
      end
    end
  end

  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && last |-> kind == KIND_DONE)
    else $error("last set on a non-completion result");

  a_hit_only_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && hit |-> kind == KIND_DONE && mem_address == 32'd0)
    else $error("hit set on a memory request");

  a_alloc_sets_valid: assert property (@(posedge clk) disable iff (rst)
    state == BK_LOOK && look_we |=> line_valid[cur_idx])
    else $error("allocated line not marked valid");

  a_flush_cleans: assert property (@(posedge clk) disable iff (rst)
    state == BK_EMIT && cur.operation == OP_FLUSH |-> line_dirty == '0)
    else $error("dirty line left after flush sweep");

  a_dirty_needs_valid: assert property (@(posedge clk) disable iff (rst)
    (line_dirty & ~line_valid) == '0)
    else $error("dirty mark on an invalid line");

endmodule

>>> rtl/direct_mapped_writeback_dcache_top.sv
// Top level of the direct-mapped write-back data cache.
//
// Request channel (req_valid / req_stall): operation, address, write_data,
// cacheable and mem_read_data, taken when req_valid is high and req_stall low.
// Result channel (rsp_valid / rsp_stall): kind, mem_address, data, hit, last.
// Each request gives one to three results (a flush gives one per dirty line)
// ending with a completion that has last set: write-back, then read request,
// then completion. A result is held steady while rsp_stall is high.
// With a power-of-two line count the index is taken from the address bits;
// other line counts first have the front end work out the index remainder,
// 8 address bits a cycle. The back-end sequencer (queue pop, registered
// line-store read, decide, then the results in turn) sets the pace for a
// read or write. A flush visits every line, reading and then checking each.
// The front end takes the next request while the back end is busy; a
// two-entry queue sits between them. A stalled result stops the back end
// only; requests keep queueing until the queue is full.
// Reset clears valid and dirty marks in flip-flops at once: no clearing pass.
module direct_mapped_writeback_dcache_top #(
  parameter int unsigned NUM_LINES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic        cacheable,
  input  logic [31:0] mem_read_data,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  kind,
  output logic [31:0] mem_address,
  output logic [31:0] data,
  output logic        hit,
  output logic        last
);
  import dmc_pkg::*;

  localparam int unsigned Q_W = REQ_W + $clog2(NUM_LINES);

  logic           q_push;
  logic [Q_W-1:0] q_push_data;
  logic           q_full;
  logic           q_pop;
  logic [Q_W-1:0] q_head;
  logic           q_empty;

  // Front end: request intake and line index
  dmc_front #(
    .NUM_LINES(NUM_LINES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .operation    (operation),
    .address      (address),
    .write_data   (write_data),
    .cacheable    (cacheable),
    .mem_read_data(mem_read_data),
    .push         (q_push),
    .push_data    (q_push_data),
    .q_full       (q_full)
  );

  // Decoupling queue
  dmc_fifo #(
    .WIDTH(Q_W)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Back end: line store and result sequencing
  dmc_back #(
    .NUM_LINES(NUM_LINES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .kind       (kind),
    .mem_address(mem_address),
    .data       (data),
    .hit        (hit),
    .last       (last)
  );

endmodule
